@@ rtl/bbd_pkg.sv @@
// Package for the Bernstein basis evaluator: widths, states and helper functions.
// Used by bbd_mul and bernstein_basis_with_derivatives_top; depends on nothing.

package bbd_pkg;

    localparam int MAX_DEGREE = 15;
    localparam int DEG_W      = 4;
    localparam int POS_W      = 17;
    localparam int ROW_W      = 31;
    localparam int MUL_A_W    = 35;
    localparam int MUL_B_W    = 18;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int OUT_W      = 32;
    localparam int NUM_ROWS   = MAX_DEGREE + 1;

    localparam logic [POS_W-1:0] ONE_Q16 = POS_W'(1 << 16);
    localparam logic [ROW_W-1:0] ONE_Q30 = ROW_W'(1 << 30);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW_START,
        ST_MUL_W,
        ST_MUL_U,
        ST_WRITE,
        ST_OUT_READ,
        ST_D1,
        ST_D2,
        ST_D3,
        ST_EMIT
    } state_t;

    function automatic logic [7:0] coef2(input logic [DEG_W-1:0] p);
        logic [7:0] a;
        a = {4'b0, p};
        return 8'(a * (a - 8'd1));
    endfunction

    function automatic logic [11:0] coef3(input logic [DEG_W-1:0] p);
        logic [11:0] a;
        a = {8'b0, p};
        return 12'(a * (a - 12'd1) * (a - 12'd2));
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_q16(input logic signed [PROD_W-1:0] x);
        logic              neg;
        logic [PROD_W-1:0] mag;
        logic [39:0]       r;
        neg = x[PROD_W-1];
        mag = neg ? PROD_W'(-x) : PROD_W'(x);
        r   = 40'(({1'b0, mag} + (PROD_W+1)'(8192)) >> 14);
        if (neg)
        begin
            if (r > 40'h0080000000)
                return 32'sh80000000;
            else
                return $signed(32'(-r));
        end
        else
        begin
            if (r > 40'h007FFFFFFF)
                return 32'sh7FFFFFFF;
            else
                return $signed(r[31:0]);
        end
    endfunction

endpackage

@@ rtl/bbd_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on bbd_pkg for operand widths.

module bbd_mul
    import bbd_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [PROD_W-1:0]  prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

@@ rtl/bernstein_basis_with_derivatives_top.sv @@
// Bernstein basis evaluator with first, second and third derivatives.
// Depends on bbd_pkg and bbd_mul (one shared multiplier for rows and derivatives).
// One position word keeps busy high from its accepted start until the sequencer returns to idle:
// each triangle entry passes ST_MUL_W, ST_MUL_U and ST_WRITE; each result ST_OUT_READ, ST_D1 to ST_EMIT.
// Results come with a one-cycle strobe; the receiver cannot stall.
// Reset (async, active low) idles the sequencer and sets degree to 3.

module bernstein_basis_with_derivatives_top
    import bbd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    degree_wen,
    input  logic [DEG_W-1:0]        degree_wdata,
    input  logic                    start,
    output logic                    busy,
    input  logic [POS_W-1:0]        position,
    output logic                    result_valid,
    output logic [DEG_W-1:0]        basis_index,
    output logic [POS_W-1:0]        basis_value,
    output logic signed [OUT_W-1:0] first_derivative,
    output logic signed [OUT_W-1:0] second_derivative,
    output logic signed [OUT_W-1:0] third_derivative,
    output logic                    last_of_run
);

    state_t           state_reg, state_next;
    logic [DEG_W-1:0] idx_reg, idx_next;
    logic [DEG_W-1:0] q_reg, q_next;
    logic             valid_reg, valid_next;
    logic [DEG_W-1:0] degree_reg;

    logic [POS_W-1:0] u_reg, w_reg, u_clamp;
    logic [DEG_W-1:0] p_reg;
    logic [3:0]       c1_reg;
    logic [7:0]       c2_reg;
    logic [11:0]      c3_reg;

    logic [ROW_W-1:0] w_row_reg  [NUM_ROWS];
    logic [ROW_W-1:0] h1_row_reg [NUM_ROWS];
    logic [ROW_W-1:0] h2_row_reg [NUM_ROWS];
    logic [ROW_W-1:0] h3_row_reg [NUM_ROWS];

    logic [ROW_W-1:0] prev_reg, cur_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic [ROW_W-1:0] h1m1_reg, h2m1_reg, h2m2_reg, h3m1_reg, h3m2_reg, h3m3_reg;
    logic signed [MUL_A_W-1:0] diff1_reg, diff2_reg, diff3_reg;
    logic signed [MUL_A_W-1:0] diff1_next, diff2_next, diff3_next;
    logic [POS_W-1:0] basis_reg;
    logic signed [OUT_W-1:0] d1_reg, d2_reg;

    logic [DEG_W-1:0]        index_out_reg;
    logic [POS_W-1:0]        value_out_reg;
    logic signed [OUT_W-1:0] first_out_reg, second_out_reg, third_out_reg;
    logic                    last_out_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic [PROD_W:0]           row_sum;
    logic [ROW_W-1:0]          row_new;
    logic [ROW_W:0]            basis_sum;
    logic [ROW_W-1:0]          t1, t2, t3, w_rd;
    logic [MUL_A_W-1:0]        x3m2, x3m1;
    logic                      accept;

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign u_clamp = (position > ONE_Q16) ? ONE_Q16 : position;

    bbd_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign w_rd = w_row_reg[idx_reg];
    assign t1   = h1_row_reg[idx_reg];
    assign t2   = h2_row_reg[idx_reg];
    assign t3   = h3_row_reg[idx_reg];

    assign row_sum   = {1'b0, $unsigned(acc_reg)} + {1'b0, $unsigned(prod)}
                       + (PROD_W+1)'(32768);
    assign row_new   = row_sum[ROW_W+15:16];
    assign basis_sum = {1'b0, w_rd} + (ROW_W+1)'(8192);

    assign x3m2 = {4'b0, h3m2_reg} + {3'b0, h3m2_reg, 1'b0};
    assign x3m1 = {4'b0, h3m1_reg} + {3'b0, h3m1_reg, 1'b0};

    always_comb
    begin
        diff1_next = $signed({4'b0, h1m1_reg}) - $signed({4'b0, t1});
        diff2_next = $signed({4'b0, h2m2_reg}) - $signed({3'b0, h2m1_reg, 1'b0})
                     + $signed({4'b0, t2});
        diff3_next = $signed({4'b0, h3m3_reg}) - $signed(x3m2) + $signed(x3m1)
                     - $signed({4'b0, t3});
    end

    always_comb
    begin
        case (state_reg)
            ST_MUL_W:
            begin
                mul_a = $signed({4'b0, w_rd});
                mul_b = $signed({1'b0, w_reg});
            end
            ST_MUL_U:
            begin
                mul_a = $signed({4'b0, prev_reg});
                mul_b = $signed({1'b0, u_reg});
            end
            ST_D1:
            begin
                mul_a = diff1_reg;
                mul_b = $signed({14'b0, c1_reg});
            end
            ST_D2:
            begin
                mul_a = diff2_reg;
                mul_b = $signed({10'b0, c2_reg});
            end
            ST_D3:
            begin
                mul_a = diff3_reg;
                mul_b = $signed({6'b0, c3_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            q_reg      <= '0;
            valid_reg  <= 1'b0;
            degree_reg <= DEG_W'(3);
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            q_reg     <= q_next;
            valid_reg <= valid_next;
            if (degree_wen)
                degree_reg <= degree_wdata;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        q_next     = q_reg;
        valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    idx_next   = '0;
                    q_next     = DEG_W'(1);
                    state_next = (degree_reg == '0) ? ST_OUT_READ : ST_ROW_START;
                end
            end
            ST_ROW_START:
            begin
                idx_next   = '0;
                state_next = ST_MUL_W;
            end
            ST_MUL_W:
                state_next = ST_MUL_U;
            ST_MUL_U:
                state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (idx_reg == q_reg)
                begin
                    idx_next = '0;
                    if (q_reg == p_reg)
                        state_next = ST_OUT_READ;
                    else
                    begin
                        q_next     = q_reg + DEG_W'(1);
                        state_next = ST_ROW_START;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + DEG_W'(1);
                    state_next = ST_MUL_W;
                end
            end
            ST_OUT_READ:
                state_next = ST_D1;
            ST_D1:
                state_next = ST_D2;
            ST_D2:
                state_next = ST_D3;
            ST_D3:
                state_next = ST_EMIT;
            ST_EMIT:
            begin
                valid_next = 1'b1;
                if (idx_reg == p_reg)
                    state_next = ST_IDLE;
                else
                begin
                    idx_next   = idx_reg + DEG_W'(1);
                    state_next = ST_OUT_READ;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    u_reg  <= u_clamp;
                    w_reg  <= ONE_Q16 - u_clamp;
                    p_reg  <= degree_reg;
                    c1_reg <= degree_reg;
                    c2_reg <= coef2(degree_reg);
                    c3_reg <= coef3(degree_reg);
                    for (int k = 0; k < NUM_ROWS; k++)
                    begin
                        w_row_reg[k]  <= (k == 0) ? ONE_Q30 : '0;
                        h1_row_reg[k] <= '0;
                        h2_row_reg[k] <= '0;
                        h3_row_reg[k] <= '0;
                    end
                    h1m1_reg <= '0;
                    h2m1_reg <= '0;
                    h2m2_reg <= '0;
                    h3m1_reg <= '0;
                    h3m2_reg <= '0;
                    h3m3_reg <= '0;
                end
            end
            ST_ROW_START:
            begin
                h3_row_reg <= h2_row_reg;
                h2_row_reg <= h1_row_reg;
                h1_row_reg <= w_row_reg;
                prev_reg   <= '0;
            end
            ST_MUL_W:
                cur_reg <= w_rd;
            ST_MUL_U:
                acc_reg <= prod;
            ST_WRITE:
            begin
                w_row_reg[idx_reg] <= row_new;
                prev_reg           <= cur_reg;
            end
            ST_OUT_READ:
            begin
                diff1_reg <= diff1_next;
                diff2_reg <= diff2_next;
                diff3_reg <= diff3_next;
                basis_reg <= basis_sum[ROW_W-1:14];
                h1m1_reg  <= t1;
                h2m2_reg  <= h2m1_reg;
                h2m1_reg  <= t2;
                h3m3_reg  <= h3m2_reg;
                h3m2_reg  <= h3m1_reg;
                h3m1_reg  <= t3;
            end
            ST_D2:
                d1_reg <= sat_q16(prod);
            ST_D3:
                d2_reg <= sat_q16(prod);
            ST_EMIT:
            begin
                index_out_reg  <= idx_reg;
                value_out_reg  <= basis_reg;
                first_out_reg  <= d1_reg;
                second_out_reg <= d2_reg;
                third_out_reg  <= sat_q16(prod);
                last_out_reg   <= (idx_reg == p_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid      = valid_reg;
    assign basis_index       = index_out_reg;
    assign basis_value       = value_out_reg;
    assign first_derivative  = first_out_reg;
    assign second_derivative = second_out_reg;
    assign third_derivative  = third_out_reg;
    assign last_of_run       = last_out_reg;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after start");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_of_run) |-> (basis_index == p_reg))
        else $error("last word index differs from degree");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_of_run) |-> busy)
        else $error("run ended before last word");

    a_basis_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (basis_value <= ONE_Q16))
        else $error("basis value above one");
`endif

endmodule

@@ sim/bernstein_basis_with_derivatives_top_tb.sv @@
// Testbench for bernstein_basis_with_derivatives_top: drives position words across degrees,
// predicts every basis word with its derivatives and checks each strobed result in order.
// Depends on bbd_pkg and the RTL of bernstein_basis_with_derivatives_top.

module bernstein_basis_with_derivatives_top_tb;
    import bbd_pkg::*;

    typedef struct {
        logic [DEG_W-1:0]        idx;
        logic [POS_W-1:0]        value;
        logic signed [OUT_W-1:0] d1;
        logic signed [OUT_W-1:0] d2;
        logic signed [OUT_W-1:0] d3;
        logic                    last_flag;
    } basis_word_t;

    class basis_word_scoreboard;
        logic [DEG_W-1:0] degree;
        longint           rows [NUM_ROWS][NUM_ROWS];
        basis_word_t      expected_words [$];
        int               mismatches;

        function new();
            degree     = DEG_W'(3);
            mismatches = 0;
        endfunction

        function void set_degree(logic [DEG_W-1:0] d);
            degree = d;
        endfunction

        function longint row_term(int q, int j);
            if (q < 0 || j < 0 || j > q)
                return 0;
            return rows[q][j];
        endfunction

        function logic signed [OUT_W-1:0] q30_to_q16(longint x);
            longint mag;
            longint r;
            mag = (x < 0) ? -x : x;
            r   = (mag + 64'sd8192) >>> 14;
            if (x < 0)
                return (r > 64'sd2147483648) ? 32'sh80000000 : OUT_W'(-r);
            return (r > 64'sd2147483647) ? 32'sh7FFFFFFF : OUT_W'(r);
        endfunction

        function void note_position(logic [POS_W-1:0] pos);
            longint      u;
            longint      w;
            longint      a;
            longint      b;
            longint      pp;
            longint      d1;
            longint      d2;
            longint      d3;
            int          p;
            basis_word_t word;
            u = (pos > ONE_Q16) ? 64'sd65536 : longint'(pos);
            w = 64'sd65536 - u;
            p = int'(degree);
            if (p > MAX_DEGREE)
                p = MAX_DEGREE;
            rows[0][0] = 64'sd1 << 30;
            for (int q = 1; q <= p; q++)
            begin
                for (int i = 0; i <= q; i++)
                begin
                    a = (i < q) ? rows[q-1][i] : 0;
                    b = (i > 0) ? rows[q-1][i-1] : 0;
                    rows[q][i] = (w * a + u * b + 64'sd32768) >>> 16;
                end
            end
            pp = p;
            for (int i = 0; i <= p; i++)
            begin
                d1 = 0;
                d2 = 0;
                d3 = 0;
                if (p >= 1)
                    d1 = pp * (row_term(p-1, i-1) - row_term(p-1, i));
                if (p >= 2)
                    d2 = pp * (pp - 1) * (row_term(p-2, i-2) - 2 * row_term(p-2, i-1)
                                          + row_term(p-2, i));
                if (p >= 3)
                    d3 = pp * (pp - 1) * (pp - 2) *
                         (row_term(p-3, i-3) - 3 * row_term(p-3, i-2)
                          + 3 * row_term(p-3, i-1) - row_term(p-3, i));
                word.idx       = DEG_W'(i);
                word.value     = POS_W'((rows[p][i] + 64'sd8192) >>> 14);
                word.d1        = q30_to_q16(d1);
                word.d2        = q30_to_q16(d2);
                word.d3        = q30_to_q16(d3);
                word.last_flag = (i == p);
                expected_words.push_back(word);
            end
        endfunction

        function void check_word(basis_word_t got);
            basis_word_t want;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: idx %0d value %0d d1 %0d d2 %0d d3 %0d last %0b",
                             got.idx, got.value, got.d1, got.d2, got.d3, got.last_flag);
                return;
            end
            want = expected_words.pop_front();
            if (got.idx !== want.idx || got.value !== want.value || got.d1 !== want.d1 ||
                got.d2 !== want.d2 || got.d3 !== want.d3 || got.last_flag !== want.last_flag)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch exp: idx %0d value %0d d1 %0d d2 %0d d3 %0d last %0b",
                             want.idx, want.value, want.d1, want.d2, want.d3, want.last_flag);
                    $display("         act: idx %0d value %0d d1 %0d d2 %0d d3 %0d last %0b",
                             got.idx, got.value, got.d1, got.d2, got.d3, got.last_flag);
                end
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    degree_wen;
    logic [DEG_W-1:0]        degree_wdata;
    logic                    start;
    logic                    busy;
    logic [POS_W-1:0]        position;
    logic                    result_valid;
    logic [DEG_W-1:0]        basis_index;
    logic [POS_W-1:0]        basis_value;
    logic signed [OUT_W-1:0] first_derivative;
    logic signed [OUT_W-1:0] second_derivative;
    logic signed [OUT_W-1:0] third_derivative;
    logic                    last_of_run;

    basis_word_scoreboard    basis_sb;

    bernstein_basis_with_derivatives_top i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .degree_wen        (degree_wen),
        .degree_wdata      (degree_wdata),
        .start             (start),
        .busy              (busy),
        .position          (position),
        .result_valid      (result_valid),
        .basis_index       (basis_index),
        .basis_value       (basis_value),
        .first_derivative  (first_derivative),
        .second_derivative (second_derivative),
        .third_derivative  (third_derivative),
        .last_of_run       (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin : result_monitor
        basis_word_t got;
        if (rst_n && result_valid)
        begin
            got.idx       = basis_index;
            got.value     = basis_value;
            got.d1        = first_derivative;
            got.d2        = second_derivative;
            got.d3        = third_derivative;
            got.last_flag = last_of_run;
            basis_sb.check_word(got);
        end
    end

    function automatic logic [POS_W-1:0] pick_position();
        int sel;
        sel = $urandom_range(99);
        if (sel < 8)
        begin
            case ($urandom_range(7))
                0: return POS_W'(0);
                1: return POS_W'(1);
                2: return POS_W'(2);
                3: return POS_W'(32768);
                4: return POS_W'(65535);
                5: return ONE_Q16;
                6: return POS_W'(65537);
                default: return '1;
            endcase
        end
        if (sel < 18)
            return POS_W'($urandom_range(131071, 65537));
        return POS_W'($urandom_range(65536, 0));
    endfunction

    task automatic send_position(input logic [POS_W-1:0] pos, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start    <= 1'b1;
        position <= pos;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        basis_sb.note_position(pos);
        @(negedge clk);
    endtask

    task automatic drain_words();
        start <= 1'b0;
        @(posedge clk);
        while (basis_sb.expected_words.size() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_degree(input logic [DEG_W-1:0] d);
        degree_wen   <= 1'b1;
        degree_wdata <= d;
        @(posedge clk);
        basis_sb.set_degree(d);
        @(negedge clk);
        degree_wen   <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [POS_W-1:0] directed_positions [12];
        int               phase_degree [12];
        int               idle_pcts [3];
        int               idle_pct;
        int               word_count;
        directed_positions = '{POS_W'(0), POS_W'(1), POS_W'(2), POS_W'(16384), POS_W'(32768),
                               POS_W'(49152), POS_W'(65535), ONE_Q16, POS_W'(65537),
                               POS_W'('h15555), POS_W'('h0AAAA), '1};
        phase_degree = '{0, 15, 1, 2, 7, 14, 5, 3, 0, 0, 0, 0};
        idle_pcts    = '{0, 68, 29};
        for (int k = 8; k < 12; k++)
            phase_degree[k] = $urandom_range(12);
        basis_sb     = new();
        rst_n        = 1'b0;
        degree_wen   = 1'b0;
        degree_wdata = '0;
        start        = 1'b0;
        position     = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_positions[k])
            send_position(directed_positions[k], 0);
        drain_words();

        for (int ph = 0; ph < 12; ph++)
        begin
            write_degree(DEG_W'(phase_degree[ph]));
            idle_pct   = idle_pcts[ph % 3];
            word_count = (phase_degree[ph] == MAX_DEGREE) ? 20 : 40;
            send_position(POS_W'(0), idle_pct);
            send_position(ONE_Q16, idle_pct);
            send_position('1, idle_pct);
            for (int n = 0; n < word_count; n++)
                send_position(pick_position(), idle_pct);
            drain_words();
        end

        if (basis_sb.mismatches == 0)
            $display("bernstein_basis_with_derivatives_top regression: pass");
        else
            $display("bernstein_basis_with_derivatives_top regression: fail");
        $finish;
    end

    initial
    begin : run_limit
        #4000000;
        $display("bernstein_basis_with_derivatives_top regression: fail");
        $finish;
    end

endmodule
